### src/rgb_led_fade_and_scan_unit_macros.svh
// Assertion macros shared by the checker of the LED fade and scan unit.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef RGB_LED_FADE_AND_SCAN_UNIT_MACROS_SVH
`define RGB_LED_FADE_AND_SCAN_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RLFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RLFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/rlfs_pkg.sv
// Package of the LED fade and scan unit: sizes, command codes and queue item type.
// Depends on nothing.
package rlfs_pkg;

	localparam int NUM_LEDS    = 8;
	localparam int LEVEL_BITS  = 15;
	localparam int CHANNELS    = 4;
	localparam int LED_BITS    = ($clog2(NUM_LEDS) > 0) ? $clog2(NUM_LEDS) : 1;
	localparam int ENTRY_BITS  = LED_BITS + 2;
	localparam int NUM_ENTRIES = NUM_LEDS * CHANNELS;
	localparam int LINE_BITS   = $clog2(NUM_LEDS + 1);
	localparam int RATE_BITS   = LEVEL_BITS + 1;
	localparam int FADE_BITS   = 16;
	localparam int CNT_BITS    = $clog2(LEVEL_BITS + 1);
	localparam int LEVEL_MAX   = (1 << LEVEL_BITS) - 1;
	localparam int BRIGHT_RESET = (10000 > LEVEL_MAX) ? LEVEL_MAX : 10000;

	localparam logic [1:0] CMD_SET_ONE = 2'd0;
	localparam logic [1:0] CMD_SET_ALL = 2'd1;
	localparam logic [1:0] CMD_FADE    = 2'd2;
	localparam logic [1:0] CMD_SCAN    = 2'd3;

	localparam logic [1:0] CH_BRIGHT = 2'd3;

	typedef enum logic [1:0] {
		OP_SET_ONE = 2'd0,
		OP_SET_ALL = 2'd1,
		OP_FADE    = 2'd2,
		OP_SCAN    = 2'd3
	} op_t;

	typedef logic [LEVEL_BITS-1:0] level_t;
	typedef logic signed [RATE_BITS-1:0] rate_t;

	typedef struct packed {
		op_t                              op;
		logic [LED_BITS-1:0]              led;
		logic [CHANNELS-1:0][LEVEL_BITS-1:0] tgt;
		logic [FADE_BITS-1:0]             fade;
	} qitem_t;

endpackage

### src/rlfs_if.sv
// Valid/ready channel interfaces for the command beats and the scan result beats.
// Depends on nothing.
interface rlfs_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [2:0]  led_index;
	logic [14:0] red_target;
	logic [14:0] green_target;
	logic [14:0] blue_target;
	logic [14:0] bright_target;
	logic [15:0] fade_ms;
	modport source (output valid, command, led_index, red_target, green_target,
		blue_target, bright_target, fade_ms, input ready);
	modport sink (input valid, command, led_index, red_target, green_target,
		blue_target, bright_target, fade_ms, output ready);
endinterface

interface rlfs_out_if;
	logic        valid;
	logic        ready;
	logic        red_sink;
	logic        green_sink;
	logic        blue_sink;
	logic [3:0]  active_line;
	logic [14:0] slot_time;
	modport source (output valid, red_sink, green_sink, blue_sink, active_line,
		slot_time, input ready);
	modport sink (input valid, red_sink, green_sink, blue_sink, active_line,
		slot_time, output ready);
endinterface

### src/rlfs_front.sv
// Front end: accepts command beats, classifies them and queues them (two entries).
// Depends on rlfs_pkg and rlfs_in_if.
module rlfs_front (
	input  logic            clk,
	input  logic            arst_n,
	rlfs_in_if.sink         in_ch,
	output logic            q_valid,
	output rlfs_pkg::qitem_t q_item,
	input  logic            q_ready
);

	rlfs_pkg::qitem_t fifo_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	rlfs_pkg::qitem_t cls;
	logic             keep;
	logic             push;
	logic             pop;

	always_comb begin
		keep = 1'b1;
		cls.led = rlfs_pkg::LED_BITS'(in_ch.led_index);
		cls.tgt[0] = rlfs_pkg::LEVEL_BITS'(in_ch.red_target);
		cls.tgt[1] = rlfs_pkg::LEVEL_BITS'(in_ch.green_target);
		cls.tgt[2] = rlfs_pkg::LEVEL_BITS'(in_ch.blue_target);
		cls.tgt[3] = rlfs_pkg::LEVEL_BITS'(in_ch.bright_target);
		// A zero fade time behaves as one tick.
		cls.fade = (in_ch.fade_ms == '0) ? rlfs_pkg::FADE_BITS'(1) : in_ch.fade_ms;
		unique case (in_ch.command)
			rlfs_pkg::CMD_SET_ONE: begin
				cls.op = rlfs_pkg::OP_SET_ONE;
				// Set-one to a missing LED has no effect and is dropped here.
				keep = (5'(in_ch.led_index) < 5'(rlfs_pkg::NUM_LEDS));
			end
			rlfs_pkg::CMD_SET_ALL: cls.op = rlfs_pkg::OP_SET_ALL;
			rlfs_pkg::CMD_FADE:    cls.op = rlfs_pkg::OP_FADE;
			default:               cls.op = rlfs_pkg::OP_SCAN;
		endcase
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready && keep;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = fifo_q[rd_ptr_q];
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### src/rlfs_back.sv
// Back end: holds the channel levels, runs set commands through a serial divider,
// walks fade ticks one channel a cycle and produces scan beats. Depends on rlfs_pkg.
module rlfs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  rlfs_pkg::qitem_t q_item,
	output logic             q_ready,
	rlfs_out_if.source       out_ch
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIFF = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_RATE = 5'b01000,
		ST_FADE = 5'b10000
	} state_t;

	localparam int SUM_BITS = rlfs_pkg::LEVEL_BITS + 2;

	state_t                  state_q;
	rlfs_pkg::level_t        cur_q  [rlfs_pkg::NUM_ENTRIES];
	rlfs_pkg::level_t        tgt_q  [rlfs_pkg::NUM_ENTRIES];
	rlfs_pkg::rate_t         rate_q [rlfs_pkg::NUM_ENTRIES];
	rlfs_pkg::qitem_t        job_q;
	logic [rlfs_pkg::LED_BITS-1:0]  led_q;
	logic [1:0]                     ch_q;
	logic [rlfs_pkg::CNT_BITS-1:0]  cnt_q;
	logic [rlfs_pkg::FADE_BITS-1:0] rem_q;
	rlfs_pkg::level_t               quo_q;
	logic                           neg_q;
	logic                           nz_q;
	logic [rlfs_pkg::LED_BITS-1:0]  scan_led_q;
	logic [1:0]                     scan_ch_q;
	logic [rlfs_pkg::LINE_BITS-1:0] line_q;

	logic                    ovld_q;
	logic                    red_q, green_q, blue_q;
	logic [3:0]              line_out_q;
	logic [14:0]             slot_q;

	logic [rlfs_pkg::ENTRY_BITS-1:0] work_idx;
	logic [rlfs_pkg::ENTRY_BITS-1:0] rd_idx;
	rlfs_pkg::level_t        cur_rd;
	rlfs_pkg::level_t        tgt_rd;
	rlfs_pkg::rate_t         rate_rd;
	rlfs_pkg::level_t        new_tgt;
	logic signed [rlfs_pkg::RATE_BITS-1:0] diff;
	logic [rlfs_pkg::FADE_BITS:0] shifted;
	logic                    qbit;
	rlfs_pkg::rate_t         quo_s;
	rlfs_pkg::rate_t         new_rate;
	logic signed [SUM_BITS-1:0] sum;
	logic signed [SUM_BITS-1:0] tgt_s;
	logic                    take;
	logic                    scan_go;
	logic                    last_ch;
	logic                    last_led;
	logic                    on;

	assign work_idx = {led_q, ch_q};
	assign rd_idx = (state_q == ST_IDLE) ? {scan_led_q, scan_ch_q} : work_idx;
	assign cur_rd = cur_q[rd_idx];
	assign tgt_rd = tgt_q[work_idx];
	assign rate_rd = rate_q[work_idx];
	assign last_ch = (ch_q == 2'd3);
	assign last_led = (32'(led_q) == rlfs_pkg::NUM_LEDS - 1);

	assign q_ready = (state_q == ST_IDLE) &&
		((q_item.op != rlfs_pkg::OP_SCAN) || !ovld_q || out_ch.ready);
	assign take = q_valid && q_ready;
	assign scan_go = take && (q_item.op == rlfs_pkg::OP_SCAN);
	assign on = (cur_rd > rlfs_pkg::level_t'(1));

	always_comb begin
		new_tgt = job_q.tgt[ch_q];
		diff = $signed({1'b0, new_tgt}) - $signed({1'b0, cur_rd});
		shifted = {rem_q, quo_q[rlfs_pkg::LEVEL_BITS-1]};
		qbit = (shifted >= {1'b0, job_q.fade});
		quo_s = $signed({1'b0, quo_q});
		if (quo_q == '0) begin
			new_rate = nz_q ? (neg_q ? -rlfs_pkg::rate_t'(1) : rlfs_pkg::rate_t'(1)) : '0;
		end else begin
			new_rate = neg_q ? -quo_s : quo_s;
		end
		sum = $signed({2'b00, cur_rd}) + SUM_BITS'(rate_rd);
		tgt_s = $signed({2'b00, tgt_rd});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < rlfs_pkg::NUM_ENTRIES; i++) begin
				cur_q[i] <= ((i % rlfs_pkg::CHANNELS) == rlfs_pkg::CHANNELS - 1) ?
					rlfs_pkg::LEVEL_BITS'(rlfs_pkg::BRIGHT_RESET) : '0;
				tgt_q[i] <= '0;
				rate_q[i] <= '0;
			end
			led_q <= '0;
			ch_q <= '0;
			cnt_q <= '0;
			scan_led_q <= '0;
			scan_ch_q <= '0;
			line_q <= rlfs_pkg::LINE_BITS'(rlfs_pkg::NUM_LEDS);
			ovld_q <= 1'b0;
		end else begin
			if (out_ch.ready) begin
				ovld_q <= 1'b0;
			end
			if (scan_go) begin
				ovld_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						job_q <= q_item;
						ch_q <= '0;
						case (q_item.op)
							rlfs_pkg::OP_SET_ONE: begin
								led_q <= q_item.led;
								state_q <= ST_DIFF;
							end
							rlfs_pkg::OP_SET_ALL: begin
								led_q <= '0;
								state_q <= ST_DIFF;
							end
							rlfs_pkg::OP_FADE: begin
								led_q <= '0;
								state_q <= ST_FADE;
							end
							default: begin
								if (scan_ch_q == 2'd3) begin
									line_q <= rlfs_pkg::LINE_BITS'(scan_led_q);
									scan_led_q <= (32'(scan_led_q) == rlfs_pkg::NUM_LEDS - 1)
										? '0 : scan_led_q + 1'b1;
								end
								scan_ch_q <= scan_ch_q + 2'd1;
							end
						endcase
					end
				end
				ST_DIFF: begin
					neg_q <= diff[rlfs_pkg::RATE_BITS-1];
					nz_q <= (diff != '0);
					quo_q <= rlfs_pkg::LEVEL_BITS'(diff[rlfs_pkg::RATE_BITS-1] ? -diff : diff);
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= qbit ? rlfs_pkg::FADE_BITS'(shifted - {1'b0, job_q.fade})
						: rlfs_pkg::FADE_BITS'(shifted);
					quo_q <= {quo_q[rlfs_pkg::LEVEL_BITS-2:0], qbit};
					cnt_q <= cnt_q + 1'b1;
					if (32'(cnt_q) == rlfs_pkg::LEVEL_BITS - 1) begin
						state_q <= ST_RATE;
					end
				end
				ST_RATE: begin
					tgt_q[work_idx] <= new_tgt;
					rate_q[work_idx] <= new_rate;
					ch_q <= ch_q + 2'd1;
					if (last_ch && ((job_q.op != rlfs_pkg::OP_SET_ALL) || last_led)) begin
						state_q <= ST_IDLE;
					end else begin
						if (last_ch) begin
							led_q <= led_q + 1'b1;
						end
						state_q <= ST_DIFF;
					end
				end
				ST_FADE: begin
					if (rate_rd > 0) begin
						if (sum < tgt_s) begin
							cur_q[work_idx] <= rlfs_pkg::LEVEL_BITS'(sum);
						end else if (rate_rd > rlfs_pkg::rate_t'(1)) begin
							rate_q[work_idx] <= rlfs_pkg::rate_t'(1);
						end else begin
							cur_q[work_idx] <= tgt_rd;
							rate_q[work_idx] <= '0;
						end
					end else if (rate_rd < 0) begin
						if (sum > tgt_s) begin
							cur_q[work_idx] <= rlfs_pkg::LEVEL_BITS'(sum);
						end else if (rate_rd < -rlfs_pkg::rate_t'(1)) begin
							rate_q[work_idx] <= -rlfs_pkg::rate_t'(1);
						end else begin
							cur_q[work_idx] <= tgt_rd;
							rate_q[work_idx] <= '0;
						end
					end
					ch_q <= ch_q + 2'd1;
					if (last_ch) begin
						led_q <= led_q + 1'b1;
						if (last_led) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register; payload carries no reset.
	always_ff @(posedge clk) begin
		if (scan_go) begin
			red_q <= (scan_ch_q == 2'd0) && on;
			green_q <= (scan_ch_q == 2'd1) && on;
			blue_q <= (scan_ch_q == 2'd2) && on;
			line_out_q <= (scan_ch_q == rlfs_pkg::CH_BRIGHT) ? 4'(scan_led_q) : 4'(line_q);
			slot_q <= 15'(cur_rd);
		end
	end

	assign out_ch.valid = ovld_q;
	assign out_ch.red_sink = red_q;
	assign out_ch.green_sink = green_q;
	assign out_ch.blue_sink = blue_q;
	assign out_ch.active_line = line_out_q;
	assign out_ch.slot_time = slot_q;

endmodule

### src/rgb_led_fade_and_scan_unit.sv
// Top level of the multiplexed RGB LED fade and scan unit.
// Depends on rlfs_pkg, rlfs_if, rlfs_front and rlfs_back.
//
// The unit keeps a current level, a target level and a signed step rate for
// each of the four channels (red, green, blue, brightness) of eight LEDs. Every
// command is one input beat; only a scan tick returns a beat, carrying the three
// colour sink lines, the enabled drive line and the slot length. The front end
// takes beats into a two-entry queue, so new commands are accepted while the
// back end is still busy or a scan result waits to be taken. The back end does
// one command at a time and takes it from the queue in ST_IDLE: a scan tick is
// done as it is taken and its beat is valid in the next cycle, a fade tick then
// steps through the channels one per cycle, and each channel of a set command
// then passes through ST_DIFF, ST_DIV and ST_RATE of the shared restoring
// divider. The channel state lives in flip-flops and is at its reset values
// right after reset, with no clearing pass. A set-one command naming an LED
// that does not exist is accepted and has no effect.
module rgb_led_fade_and_scan_unit (
	input  logic       clk,
	input  logic       arst_n,
	rlfs_in_if.sink    in_ch,
	rlfs_out_if.source out_ch
);

	// Queue handshake between the front end and the back end.
	logic             q_valid;
	logic             q_ready;
	rlfs_pkg::qitem_t q_item;

	// The front end decodes each beat and drops set-one beats with no target LED.
	rlfs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_ready (q_ready)
	);

	// The back end owns all channel state and the result register.
	rlfs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_ready (q_ready),
		.out_ch  (out_ch)
	);

endmodule

### src/rlfs_checker.sv
// Port-level checker of the LED fade and scan unit, bound to the top level.
// Depends on rlfs_pkg and the assertion macro header.
`include "rgb_led_fade_and_scan_unit_macros.svh"

module rlfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        red_sink,
	input logic        green_sink,
	input logic        blue_sink,
	input logic [3:0]  active_line,
	input logic [14:0] slot_time
);

	`RLFS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(slot_time) && $stable(active_line), "result beat changed while stalled")
	`RLFS_ASSERT_IMP(a_line, out_valid, active_line <= 4'(rlfs_pkg::NUM_LEDS), "drive line out of range")
	`RLFS_ASSERT_IMP(a_one_sink, out_valid, $countones({red_sink, green_sink, blue_sink}) <= 1, "more than one colour bus sinks")
	`RLFS_ASSERT_IMP(a_sink_level, out_valid && (red_sink || green_sink || blue_sink), slot_time > 15'd1, "bus sinks at a level of one or less")

endmodule

bind rgb_led_fade_and_scan_unit rlfs_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.red_sink    (out_ch.red_sink),
	.green_sink  (out_ch.green_sink),
	.blue_sink   (out_ch.blue_sink),
	.active_line (out_ch.active_line),
	.slot_time   (out_ch.slot_time)
);
